// ----- rtl/core/quoted_printable_decoder_unit_macros.svh -----
// Assertion macros used by the checker of the quoted-printable decoder.
// Each expects clk and arst_n in the scope where it is used.
`ifndef QUOTED_PRINTABLE_DECODER_UNIT_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define QPD_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("qpd assertion failed");

// Next-cycle implication.
`define QPD_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("qpd assertion failed");

`endif

// ----- rtl/core/qpd_pkg.sv -----
// Types and constants of the quoted-printable (Q encoding) decoder.
// No dependencies.
`default_nettype none
package qpd_pkg;

	localparam logic [7:0] CH_EQUALS     = 8'h3D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_F    = 8'h46;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_F    = 8'h66;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_EQ    = 2'd1,
		PH_DIGIT = 2'd2
	} qpd_phase_t;

	// Results of one input word plus the decoder state it leaves behind.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		qpd_phase_t phase;
		logic [3:0] nibble;
	} qpd_dec_t;

endpackage
`default_nettype wire

// ----- rtl/core/qpd_in_if.sv -----
// Input channel of the quoted-printable decoder: encoded byte and last flag.
// No dependencies.
`default_nettype none
interface qpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/qpd_out_if.sv -----
// Output channel of the quoted-printable decoder: decoded byte and run end.
// No dependencies.
`default_nettype none
interface qpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, output out_byte, output run_end, input ready);
	modport sink (input valid, input out_byte, input run_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/qpd_decode.sv -----
// Combinational decode of one encoded byte against the escape state.
// Depends on qpd_pkg.
`default_nettype none
module qpd_decode (
	input  qpd_pkg::qpd_phase_t phase,
	input  logic [3:0]          nibble,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output qpd_pkg::qpd_dec_t   dec
);
	import qpd_pkg::*;

	logic       is_hex;
	logic [3:0] hex_val;
	logic       open_esc;
	logic       p_emit;
	logic [7:0] p_byte;
	qpd_phase_t p_phase;

	always_comb begin
		is_hex  = 1'b0;
		hex_val = in_byte[3:0];
		if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
			is_hex = 1'b1;
		end else if ((in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_F) ||
				(in_byte >= CH_LOWER_A && in_byte <= CH_LOWER_F)) begin
			is_hex  = 1'b1;
			hex_val = in_byte[3:0] + 4'd9;
		end
	end

	// plain-text handling; '=' on the last byte closes as 0x00
	always_comb begin
		open_esc = (in_byte == CH_EQUALS) && !in_last;
		p_emit   = !open_esc;
		p_phase  = open_esc ? PH_EQ : PH_PLAIN;
		if (in_byte == CH_EQUALS) begin
			p_byte = 8'h00;
		end else if (in_byte == CH_UNDERSCORE) begin
			p_byte = CH_SPACE;
		end else begin
			p_byte = in_byte;
		end
	end

	always_comb begin
		dec.cnt    = 2'd0;
		dec.b0     = 8'h00;
		dec.b1     = 8'h00;
		dec.phase  = PH_PLAIN;
		dec.nibble = 4'h0;
		unique case (phase)
			PH_EQ: begin
				if (is_hex) begin
					if (in_last) begin
						dec.cnt = 2'd1;
						dec.b0  = {4'h0, hex_val};
					end else begin
						dec.phase  = PH_DIGIT;
						dec.nibble = hex_val;
					end
				end else begin
					dec.cnt = 2'd1;
					dec.b0  = in_byte;
				end
			end
			PH_DIGIT: begin
				if (is_hex) begin
					dec.cnt = 2'd1;
					dec.b0  = {nibble, hex_val};
				end else begin
					dec.b0    = {4'h0, nibble};
					dec.b1    = p_byte;
					dec.cnt   = p_emit ? 2'd2 : 2'd1;
					dec.phase = p_phase;
				end
			end
			default: begin
				dec.cnt   = p_emit ? 2'd1 : 2'd0;
				dec.b0    = p_byte;
				dec.phase = p_phase;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/quoted_printable_decoder_unit.sv -----
// Top level of the quoted-printable (Q encoding) decoder.
// Depends on qpd_pkg, qpd_in_if, qpd_out_if and qpd_decode.
//
//   channel  dir  payload             word
//   in_ch    in   in_byte, in_last    one encoded byte
//   out_ch   out  out_byte, run_end   one decoded byte
//
// One encoded byte enters per cycle while in_ch.ready is high; it waits
// in the input register until the result register can take its zero to
// two results, which load the result register together. A byte with two
// results holds the result register until both are taken. Reset clears
// the escape state and both valid flags. in_ch.ready falls only when the
// input register is full and the result register cannot drain this cycle.
`default_nettype none
module quoted_printable_decoder_unit (
	input logic       clk,
	input logic       arst_n,
	qpd_in_if.sink    in_ch,
	qpd_out_if.source out_ch
);
	import qpd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	qpd_phase_t phase_q;
	logic [3:0] nibble_q;

	logic [1:0] res_cnt_q;
	logic [7:0] res0_q;
	logic [7:0] res1_q;

	qpd_dec_t dec;
	logic     buf_free;
	logic     adv;
	logic     in_acc;
	logic     out_acc;

	qpd_decode u_decode (
		.phase   (phase_q),
		.nibble  (nibble_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.dec     (dec)
	);

	assign out_acc  = out_ch.valid && out_ch.ready;
	assign buf_free = (res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && out_ch.ready);
	assign adv      = valid_s1 && buf_free;
	assign in_ch.ready = !valid_s1 || buf_free;
	assign in_acc   = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			phase_q   <= PH_PLAIN;
			nibble_q  <= 4'h0;
			res_cnt_q <= 2'd0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				phase_q   <= dec.phase;
				nibble_q  <= dec.nibble;
				res_cnt_q <= dec.cnt;
			end else if (out_acc) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
		if (adv) begin
			res0_q <= dec.b0;
			res1_q <= dec.b1;
		end else if (out_acc) begin
			res0_q <= res1_q;
		end
	end

	assign out_ch.valid    = res_cnt_q != 2'd0;
	assign out_ch.out_byte = res0_q;
	assign out_ch.run_end  = res_cnt_q == 2'd1;

endmodule
`default_nettype wire

// ----- rtl/core/qpd_checker.sv -----
// Port-level checks of the quoted-printable decoder, bound to its top level.
// Depends on quoted_printable_decoder_unit_macros.svh.
`default_nettype none
`include "quoted_printable_decoder_unit_macros.svh"
module qpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_end
);

	// stalled word holds
	`QPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_end))
	// a word without run end is always followed by another
	`QPD_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !run_end, out_valid)
	// at most two words per input byte
	`QPD_ASSERT_NEXT(a_run_max2, out_valid && out_ready && !run_end, run_end)
	// one-word input stage: taking a byte under an output stall fills it
	`QPD_ASSERT_NEXT(a_in_fill, in_valid && in_ready && out_valid && !out_ready, !in_ready || out_ready)

endmodule

bind quoted_printable_decoder_unit qpd_checker u_qpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.run_end   (out_ch.run_end)
);
`default_nettype wire

// ----- dv/quoted_printable_decoder_unit_tb.sv -----
// Self-checking testbench of quoted_printable_decoder_unit: directed and random Q-encoded
// words, random stalls on both channels, decoded words checked against a local decoder.
// Depends on qpd_pkg, qpd_in_if, qpd_out_if and the decoder RTL.
`default_nettype none
module quoted_printable_decoder_unit_tb;
	import qpd_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} enc_word_t;

	typedef struct {
		logic [7:0] data;
		logic       run_end;
	} dec_word_t;

	logic clk;
	logic arst_n;

	qpd_in_if  in_ch();
	qpd_out_if out_ch();

	quoted_printable_decoder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	enc_word_t  enc_q[$];
	dec_word_t  dec_expect_q[$];
	logic [7:0] step_bytes[$];
	qpd_phase_t qp_phase;
	logic [3:0] qp_nibble;
	enc_word_t  drv_word;
	logic       in_taken;
	int         words_sent;
	int         total_words;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         error_count;

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR t=%0t: %s", $time, msg);
		error_count++;
	endtask

	// {is_digit, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= CH_ZERO && b <= CH_NINE)
			return {1'b1, 4'(b - CH_ZERO)};
		if (b >= CH_UPPER_A && b <= CH_UPPER_F)
			return {1'b1, 4'(b - CH_UPPER_A + 8'd10)};
		if (b >= CH_LOWER_A && b <= CH_LOWER_F)
			return {1'b1, 4'(b - CH_LOWER_A + 8'd10)};
		return 5'd0;
	endfunction

	function automatic void decode_plain(input logic [7:0] b, input logic last);
		if (b == CH_EQUALS) begin
			if (last) begin
				step_bytes.push_back(8'h00);
				qp_phase = PH_PLAIN;
			end else begin
				qp_phase = PH_EQ;
			end
		end else begin
			step_bytes.push_back(b == CH_UNDERSCORE ? CH_SPACE : b);
			qp_phase = PH_PLAIN;
		end
	endfunction

	function automatic void predict_decoded(input logic [7:0] b, input logic last);
		logic [4:0] hd;
		dec_word_t  w;
		hd = hex_digit(b);
		step_bytes.delete();
		case (qp_phase)
			PH_EQ: begin
				if (hd[4]) begin
					if (last) begin
						step_bytes.push_back({4'h0, hd[3:0]});
						qp_phase = PH_PLAIN;
					end else begin
						qp_nibble = hd[3:0];
						qp_phase = PH_DIGIT;
					end
				end else begin
					step_bytes.push_back(b);
					qp_phase = PH_PLAIN;
				end
			end
			PH_DIGIT: begin
				if (hd[4]) begin
					step_bytes.push_back({qp_nibble, hd[3:0]});
					qp_phase = PH_PLAIN;
				end else begin
					step_bytes.push_back({4'h0, qp_nibble});
					qp_phase = PH_PLAIN;
					decode_plain(b, last);
				end
			end
			default: decode_plain(b, last);
		endcase
		if (last)
			qp_phase = PH_PLAIN;
		if (qp_phase != PH_DIGIT)
			qp_nibble = 4'h0;
		foreach (step_bytes[i]) begin
			w.data = step_bytes[i];
			w.run_end = (i == step_bytes.size() - 1);
			dec_expect_q.push_back(w);
		end
	endfunction

	task automatic push_word(input logic [7:0] b, input logic last);
		enc_word_t w;
		w.data = b;
		w.last = last;
		enc_q.push_back(w);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_hex();
		case ($urandom_range(2))
			0: return CH_ZERO + 8'($urandom_range(9));
			1: return CH_UPPER_A + 8'($urandom_range(5));
			default: return CH_LOWER_A + 8'($urandom_range(5));
		endcase
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (hex_digit(b) != 5'd0)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	// One encoded string: well-formed escapes, some broken ones, underscores and noise.
	task automatic push_random_string();
		logic [7:0] bytes[$];
		int         target;
		target = $urandom_range(1, 12);
		while (bytes.size() < target) begin
			case ($urandom_range(9))
				0, 1: bytes.push_back(8'($urandom_range(255)));
				2: bytes.push_back(CH_UNDERSCORE);
				3, 4, 5: begin
					bytes.push_back(CH_EQUALS);
					bytes.push_back(rand_hex());
					bytes.push_back(rand_hex());
				end
				6: begin
					bytes.push_back(CH_EQUALS);
					bytes.push_back(rand_nonhex());
				end
				7: begin
					bytes.push_back(CH_EQUALS);
					bytes.push_back(rand_hex());
					bytes.push_back(rand_nonhex());
				end
				default: bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
			endcase
		end
		// open escape at end of string
		case ($urandom_range(5))
			0: bytes.push_back(CH_EQUALS);
			1: begin
				bytes.push_back(CH_EQUALS);
				bytes.push_back(rand_hex());
			end
			default: ;
		endcase
		foreach (bytes[i])
			push_word(bytes[i], i == bytes.size() - 1);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			case (words_sent * 3 / total_words)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 66;
				end
				1: begin
					send_idle_pct = 66;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (!in_ch.valid || in_taken) begin
				if (enc_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_word = enc_q.pop_front();
					words_sent++;
					in_ch.valid   <= 1'b1;
					in_ch.in_byte <= drv_word.data;
					in_ch.in_last <= drv_word.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		dec_word_t exp_word;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready)
				predict_decoded(in_ch.in_byte, in_ch.in_last);
			if (out_ch.valid && out_ch.ready) begin
				if (dec_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word out_byte=%02h run_end=%0b",
						out_ch.out_byte, out_ch.run_end));
				end else begin
					exp_word = dec_expect_q.pop_front();
					if (out_ch.out_byte !== exp_word.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_ch.out_byte, exp_word.data));
					if (out_ch.run_end !== exp_word.run_end)
						report_mismatch($sformatf("run_end %0b, expected %0b (byte %02h)",
							out_ch.run_end, exp_word.run_end, exp_word.data));
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		out_ch.ready = 1'b0;
		in_taken = 1'b0;
		words_sent = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		qp_phase = PH_PLAIN;
		qp_nibble = 4'h0;

		// directed: byte extremes, underscore, mixed case, raw after equals,
		// one digit then non-hex, open escape and single digit at end
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b0);
		push_text("_=aF=_==");
		push_text("=9z=0=f0");
		push_text("=");
		push_text("=C");
		push_text("=7_");
		while (enc_q.size() < 474)
			push_random_string();
		total_words = enc_q.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (enc_q.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (dec_expect_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
